/* rtl/jts_pkg.sv */
`default_nettype none

package jts_pkg;

   localparam int MAX_TOKENS  = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int SLOT_BITS   = $clog2(MAX_TOKENS);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_STRING  = 3'd1;
   localparam logic [2:0] MODE_NUMBER  = 3'd2;
   localparam logic [2:0] MODE_KEYWORD = 3'd3;
   localparam logic [2:0] MODE_ERROR   = 3'd4;

   localparam logic [3:0] KIND_STRING   = 4'd0;
   localparam logic [3:0] KIND_NUMBER   = 4'd1;
   localparam logic [3:0] KIND_COMMA    = 4'd2;
   localparam logic [3:0] KIND_LBRACKET = 4'd3;
   localparam logic [3:0] KIND_RBRACKET = 4'd4;
   localparam logic [3:0] KIND_COLON    = 4'd5;
   localparam logic [3:0] KIND_LBRACE   = 4'd6;
   localparam logic [3:0] KIND_RBRACE   = 4'd7;
   localparam logic [3:0] KIND_TRUE     = 4'd8;
   localparam logic [3:0] KIND_END      = 4'd11;
   localparam logic [3:0] KIND_ERROR    = 4'd12;

   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;

   localparam logic [7:0] CHAR_DQUOTE   = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE   = 8'h27;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_COMMA    = 8'h2C;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
   localparam logic [7:0] CHAR_0        = 8'h30;
   localparam logic [7:0] CHAR_9        = 8'h39;
   localparam logic [7:0] CHAR_LA       = 8'h61;
   localparam logic [7:0] CHAR_LZ       = 8'h7A;
   localparam logic [7:0] CHAR_UA       = 8'h41;
   localparam logic [7:0] CHAR_UZ       = 8'h5A;
   localparam logic [7:0] CHAR_T        = 8'h74;
   localparam logic [7:0] CHAR_F        = 8'h66;
   localparam logic [7:0] CHAR_N        = 8'h6E;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic [15:0] column;
   } token_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]              count;
      token_type [MAX_TOKENS-1:0]        tok;
   } group_type;

   function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] prog);
      logic [7:0] c;
      case ({sel, prog})
         {KW_TRUE, 3'd0}:  c = 8'h74;
         {KW_TRUE, 3'd1}:  c = 8'h72;
         {KW_TRUE, 3'd2}:  c = 8'h75;
         {KW_TRUE, 3'd3}:  c = 8'h65;
         {KW_FALSE, 3'd0}: c = 8'h66;
         {KW_FALSE, 3'd1}: c = 8'h61;
         {KW_FALSE, 3'd2}: c = 8'h6C;
         {KW_FALSE, 3'd3}: c = 8'h73;
         {KW_FALSE, 3'd4}: c = 8'h65;
         {KW_NULL, 3'd0}:  c = 8'h6E;
         {KW_NULL, 3'd1}:  c = 8'h75;
         {KW_NULL, 3'd2}:  c = 8'h6C;
         {KW_NULL, 3'd3}:  c = 8'h6C;
         default:          c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] sel);
      logic [2:0] n;
      case (sel)
         KW_TRUE:  n = 3'd4;
         KW_FALSE: n = 3'd5;
         KW_NULL:  n = 3'd4;
         default:  n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

/* rtl/jts_front.sv */
`default_nettype none

module jts_front import jts_pkg::*; #(
   parameter int OFFSET_BITS   = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept_i,
   input  wire logic [7:0] text_byte_i,
   input  wire logic       end_of_text_i,
   output group_type       group_o,
   output logic            push_o
);

   typedef logic [OFFSET_BITS-1:0]   offset_type;
   typedef logic [POSITION_BITS-1:0] position_type;

   localparam offset_type   OFF_ONE = offset_type'(1);
   localparam position_type POS_ONE = position_type'(1);

   logic [2:0]   mode_ff, mode_in;
   logic         single_ff, single_in;
   logic [1:0]   ksel_ff, ksel_in;
   logic [2:0]   kprog_ff, kprog_in;
   offset_type   pstart_ff, pstart_in;
   offset_type   plen_ff, plen_in;
   position_type pline_ff, pline_in;
   position_type pcol_ff, pcol_in;
   offset_type   coff_ff, coff_in;
   position_type cline_ff, cline_in;
   position_type ccol_ff, ccol_in;

   function automatic offset_type off_inc(input offset_type v);
      return (v == '1) ? v : v + OFF_ONE;
   endfunction

   function automatic position_type pos_inc(input position_type v);
      return (v == '1) ? v : v + POS_ONE;
   endfunction

   function automatic token_type mk(input logic [3:0] kind, input offset_type start,
                                    input offset_type len, input position_type line,
                                    input position_type col);
      token_type t;
      t.kind   = kind;
      t.start  = 16'(start);
      t.length = 16'(len);
      t.line   = 16'(line);
      t.column = 16'(col);
      return t;
   endfunction

   logic [7:0]           b;
   logic                 is_digit, is_letter, is_ws, is_quote, scan_new;
   logic [SLOT_BITS-1:0] cnt;
   logic [3:0]           pkind;
   logic [2:0]           kprog_next;

   always_comb begin
      b         = text_byte_i;
      is_digit  = (b >= CHAR_0) && (b <= CHAR_9);
      is_letter = ((b >= CHAR_LA) && (b <= CHAR_LZ)) || ((b >= CHAR_UA) && (b <= CHAR_UZ));
      is_ws     = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_NEWLINE);
      is_quote  = (b == CHAR_DQUOTE) || (b == CHAR_SQUOTE);
      scan_new  = 1'b0;
      cnt       = '0;
      pkind     = KIND_ERROR;
      kprog_next = kprog_ff + 3'd1;
      group_o   = '0;
      mode_in   = mode_ff;
      single_in = single_ff;
      ksel_in   = ksel_ff;
      kprog_in  = kprog_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      pline_in  = pline_ff;
      pcol_in   = pcol_ff;

      case (mode_ff)
         MODE_STRING: begin
            if (b == (single_ff ? CHAR_SQUOTE : CHAR_DQUOTE)) begin
               group_o.tok[cnt] = mk(KIND_STRING, pstart_ff, plen_ff, pline_ff, pcol_ff);
               cnt = cnt + 1'b1;
               mode_in = MODE_IDLE;
            end else begin
               plen_in = off_inc(plen_ff);
            end
         end
         MODE_NUMBER: begin
            if (is_digit) begin
               plen_in = off_inc(plen_ff);
            end else if (is_letter) begin
               group_o.tok[cnt] = mk(KIND_ERROR, pstart_ff, '0, pline_ff, pcol_ff);
               cnt = cnt + 1'b1;
               mode_in = MODE_ERROR;
            end else begin
               group_o.tok[cnt] = mk(KIND_NUMBER, pstart_ff, plen_ff, pline_ff, pcol_ff);
               cnt = cnt + 1'b1;
               scan_new = 1'b1;
            end
         end
         MODE_KEYWORD: begin
            if ((ksel_ff != 2'd3) && (kprog_ff < kw_len(ksel_ff))
                && (b == kw_char(ksel_ff, kprog_ff))) begin
               kprog_in = kprog_next;
               if (kprog_next == kw_len(ksel_ff)) begin
                  group_o.tok[cnt] = mk(KIND_TRUE + 4'(ksel_ff), pstart_ff,
                                        offset_type'(kw_len(ksel_ff)), pline_ff, pcol_ff);
                  cnt = cnt + 1'b1;
                  mode_in = MODE_IDLE;
               end
            end else begin
               group_o.tok[cnt] = mk(KIND_ERROR, pstart_ff, '0, pline_ff, pcol_ff);
               cnt = cnt + 1'b1;
               mode_in = MODE_ERROR;
            end
         end
         MODE_ERROR: begin
         end
         default: begin
            scan_new = 1'b1;
         end
      endcase

      if (scan_new) begin
         mode_in = MODE_IDLE;
         if (is_ws) begin
         end else if (is_quote) begin
            mode_in   = MODE_STRING;
            single_in = (b == CHAR_SQUOTE);
            pstart_in = off_inc(coff_ff);
            plen_in   = '0;
            pline_in  = cline_ff;
            pcol_in   = pos_inc(ccol_ff);
         end else if (is_digit) begin
            mode_in   = MODE_NUMBER;
            pstart_in = coff_ff;
            plen_in   = OFF_ONE;
            pline_in  = cline_ff;
            pcol_in   = ccol_ff;
         end else if ((b == CHAR_T) || (b == CHAR_F) || (b == CHAR_N)) begin
            mode_in   = MODE_KEYWORD;
            ksel_in   = (b == CHAR_T) ? KW_TRUE : (b == CHAR_F) ? KW_FALSE : KW_NULL;
            kprog_in  = 3'd1;
            pstart_in = coff_ff;
            pline_in  = cline_ff;
            pcol_in   = ccol_ff;
         end else begin
            case (b)
               CHAR_COMMA:    pkind = KIND_COMMA;
               CHAR_LBRACKET: pkind = KIND_LBRACKET;
               CHAR_RBRACKET: pkind = KIND_RBRACKET;
               CHAR_COLON:    pkind = KIND_COLON;
               CHAR_LBRACE:   pkind = KIND_LBRACE;
               CHAR_RBRACE:   pkind = KIND_RBRACE;
               default:       pkind = KIND_ERROR;
            endcase
            if (pkind == KIND_ERROR) begin
               mode_in = MODE_ERROR;
            end
            group_o.tok[cnt] = mk(pkind, coff_ff, (pkind == KIND_ERROR) ? '0 : OFF_ONE,
                                  cline_ff, ccol_ff);
            cnt = cnt + 1'b1;
         end
      end

      coff_in = off_inc(coff_ff);
      if (b == CHAR_NEWLINE) begin
         cline_in = pos_inc(cline_ff);
         ccol_in  = POS_ONE;
      end else begin
         cline_in = cline_ff;
         ccol_in  = pos_inc(ccol_ff);
      end

      if (end_of_text_i) begin
         if (mode_in == MODE_NUMBER) begin
            group_o.tok[cnt] = mk(KIND_NUMBER, pstart_in, plen_in, pline_in, pcol_in);
            cnt = cnt + 1'b1;
         end else if (mode_in == MODE_STRING) begin
            group_o.tok[cnt] = mk(KIND_STRING, pstart_in, plen_in, pline_in, pcol_in);
            cnt = cnt + 1'b1;
         end else if (mode_in == MODE_KEYWORD) begin
            group_o.tok[cnt] = mk(KIND_ERROR, pstart_in, '0, pline_in, pcol_in);
            cnt = cnt + 1'b1;
         end
         group_o.tok[cnt] = mk(KIND_END, coff_in, '0, cline_in, ccol_in);
         cnt = cnt + 1'b1;
         mode_in   = MODE_IDLE;
         single_in = 1'b0;
         ksel_in   = '0;
         kprog_in  = '0;
         pstart_in = '0;
         plen_in   = '0;
         pline_in  = POS_ONE;
         pcol_in   = POS_ONE;
         coff_in   = '0;
         cline_in  = POS_ONE;
         ccol_in   = POS_ONE;
      end

      group_o.count = cnt;
      push_o        = accept_i && (cnt != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         single_ff <= 1'b0;
         ksel_ff   <= '0;
         kprog_ff  <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
         pline_ff  <= POS_ONE;
         pcol_ff   <= POS_ONE;
         coff_ff   <= '0;
         cline_ff  <= POS_ONE;
         ccol_ff   <= POS_ONE;
      end else if (accept_i) begin
         mode_ff   <= mode_in;
         single_ff <= single_in;
         ksel_ff   <= ksel_in;
         kprog_ff  <= kprog_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
         pline_ff  <= pline_in;
         pcol_ff   <= pcol_in;
         coff_ff   <= coff_in;
         cline_ff  <= cline_in;
         ccol_ff   <= ccol_in;
      end
   end

   a_eot_emits_end: assert property (@(posedge clock) disable iff (reset)
      accept_i && end_of_text_i |-> push_o)
      else $error("end of text without a group");

   a_end_returns_idle: assert property (@(posedge clock) disable iff (reset)
      accept_i && end_of_text_i |=> mode_ff == MODE_IDLE && coff_ff == '0)
      else $error("scanner not cleared after end of text");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      accept_i && !end_of_text_i && mode_ff == MODE_ERROR |-> !push_o)
      else $error("token emitted while in error recovery");

endmodule

`default_nettype wire

/* rtl/jts_queue.sv */
`default_nettype none

module jts_queue import jts_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_i,
   input  group_type      group_i,
   input  wire logic      pop_i,
   output group_type      head_o,
   output logic           empty_o,
   output logic           full_o
);

   group_type            store_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   always_comb begin
      empty_o  = (count_ff == '0);
      full_o   = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
      head_o   = store_ff[rptr_ff];
      wptr_in  = push_i ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop_i ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (QPTR_BITS+1)'(push_i) - (QPTR_BITS+1)'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         store_ff[wptr_ff] <= group_i;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> !empty_o)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

/* rtl/jts_back.sv */
`default_nettype none

module jts_back import jts_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  group_type   head_i,
   input  wire logic   empty_i,
   output logic        pop_o,
   output logic        out_valid_o,
   input  wire logic   out_ready_i,
   output token_type   out_token_o,
   output logic        out_last_o
);

   logic                 valid_ff, valid_in;
   token_type            token_ff, token_in;
   logic                 last_ff, last_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic                 load;

   always_comb begin
      load     = !empty_i && (!valid_ff || out_ready_i);
      last_in  = (slot_ff == head_i.count - 1'b1);
      token_in = head_i.tok[slot_ff];
      pop_o    = load && last_in;
      valid_in = load || (valid_ff && !out_ready_i);
      if (!load) begin
         slot_in = slot_ff;
      end else if (last_in) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + 1'b1;
      end
      out_valid_o = valid_ff;
      out_token_o = token_ff;
      out_last_o  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         token_ff <= token_in;
         last_ff  <= last_in;
      end
   end

   a_slot_in_group: assert property (@(posedge clock) disable iff (reset)
      !empty_i |-> slot_ff < head_i.count)
      else $error("slot beyond group");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      pop_o |=> out_valid_o && out_last_o)
      else $error("group released without its last token");

   a_slot_reset_after_pop: assert property (@(posedge clock) disable iff (reset)
      pop_o |=> slot_ff == '0)
      else $error("slot not rewound after group");

endmodule

`default_nettype wire

/* rtl/json_token_scanner.sv */
`default_nettype none

// JSON token scanner. One text byte is taken per clock cycle; the scanner
// classifies it in the cycle it is transferred and writes the tokens it causes
// (zero to three) as one group into a four-group queue. The output stage sends
// one token per cycle from its own register while rsp_tready is high, so a
// byte's tokens pass through the queue and that register before they appear.
// Input stalls only when the queue holds four groups, which happens only when
// the token rate stays above one per cycle or the output is held.
module json_token_scanner import jts_pkg::*; #(
   parameter int OFFSET_BITS   = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // token_kind, token_start, token_length,
                                         // token_line, token_column, zero pad
   output logic             rsp_tlast    // last_of_run
);

   logic      accept;
   logic      push, pop, empty, full;
   group_type grp, head;
   token_type tok;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   jts_front #(
      .OFFSET_BITS   (OFFSET_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept_i      (accept),
      .text_byte_i   (req_tdata),
      .end_of_text_i (req_tlast),
      .group_o       (grp),
      .push_o        (push)
   );

   jts_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .group_i (grp),
      .pop_i   (pop),
      .head_o  (head),
      .empty_o (empty),
      .full_o  (full)
   );

   jts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_i      (head),
      .empty_i     (empty),
      .pop_o       (pop),
      .out_valid_o (rsp_tvalid),
      .out_ready_i (rsp_tready),
      .out_token_o (tok),
      .out_last_o  (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, tok.column, tok.line, tok.length, tok.start, tok.kind};

endmodule

`default_nettype wire
